[hdl/brm_pkg.sv]
// Shared types and constants of the byte register machine execute block.
package brm_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned REG_COUNT   = 32;
  localparam int unsigned REG_AW      = $clog2(REG_COUNT);
  localparam int unsigned MEM_DEPTH   = 256;
  localparam int unsigned MEM_AW      = $clog2(MEM_DEPTH);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_EXEC = 3'd0,
    KIND_WREG = 3'd1,
    KIND_WMEM = 3'd2,
    KIND_RREG = 3'd3,
    KIND_RMEM = 3'd4
  } kind_e;

  typedef enum logic [7:0] {
    OPC_AND   = 8'd0,
    OPC_OR    = 8'd1,
    OPC_ADD   = 8'd2,
    OPC_MUL   = 8'd3,
    OPC_XOR   = 8'd4,
    OPC_PRINT = 8'd5,
    OPC_SLEEP = 8'd6,
    OPC_LOAD  = 8'd7,
    OPC_STORE = 8'd8,
    OPC_BNE   = 8'd9,
    OPC_LDI   = 8'd10,
    OPC_STI   = 8'd11
  } opcode_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_AND,
    OP_OR,
    OP_ADD,
    OP_MUL,
    OP_XOR,
    OP_PRINT,
    OP_SLEEP,
    OP_LOAD,
    OP_STORE,
    OP_BNE,
    OP_LDI,
    OP_STI,
    OP_WREG,
    OP_WMEM,
    OP_RREG,
    OP_RMEM
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [REG_AW-1:0] p0;
    logic [REG_AW-1:0] p1;
    logic [REG_AW-1:0] wa;
    logic [MEM_AW-1:0] addr;
    logic [DATA_W-1:0] imm;
    logic [DATA_W-1:0] target;
  } instr_t;

endpackage

[hdl/byte_register_machine_execute_top.sv]
// Top level of the byte register machine execute block.
//
// Input channel: in_valid_i / in_stall_o carry one beat per instruction or
// register/memory access (kind, opcode, three operands). A beat is taken at a
// rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry exactly one result beat per
// input beat, in order (print, sleep, branch and read-back fields; unused
// fields are zero).
// Path: the queue head is registered by the register read, then by the
// execute/memory access into the result stage, which shows the result beat
// until an edge with out_stall_i low. Throughput: one beat per cycle, back to
// back, unless the receiver stalls; each instruction uses one two-port
// register file read, at most one register write and one byte memory access.
// Reset clears the register file and data memory to zero at once through
// per-entry valid bits, and empties the queue and pipeline.
// When the receiver stalls, the result stage holds its beat and the pipeline
// freezes; the two-entry queue keeps taking beats until it is full, then
// raises in_stall_o.
module byte_register_machine_execute_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] in_kind_i,
  input  logic [7:0] in_opcode_i,
  input  logic [7:0] in_operand_a_i,
  input  logic [7:0] in_operand_b_i,
  input  logic [7:0] in_operand_c_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_print_valid_o,
  output logic [7:0] out_print_value_o,
  output logic       out_sleep_valid_o,
  output logic [7:0] out_sleep_seconds_o,
  output logic       out_jump_taken_o,
  output logic [7:0] out_jump_target_o,
  output logic [7:0] out_read_data_o
);
  import brm_pkg::*;

  logic   push;
  logic   full;
  logic   pop;
  logic   head_valid;
  instr_t item;
  instr_t head;

  brm_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_kind_i      (in_kind_i),
    .in_opcode_i    (in_opcode_i),
    .in_operand_a_i (in_operand_a_i),
    .in_operand_b_i (in_operand_b_i),
    .in_operand_c_i (in_operand_c_i),
    .full_i         (full),
    .push_o         (push),
    .item_o         (item)
  );

  brm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  brm_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_valid_i        (head_valid),
    .head_i              (head),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_print_valid_o   (out_print_valid_o),
    .out_print_value_o   (out_print_value_o),
    .out_sleep_valid_o   (out_sleep_valid_o),
    .out_sleep_seconds_o (out_sleep_seconds_o),
    .out_jump_taken_o    (out_jump_taken_o),
    .out_jump_target_o   (out_jump_target_o),
    .out_read_data_o     (out_read_data_o)
  );

endmodule

[hdl/brm_front.sv]
// Input handshake and instruction classification.
module brm_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    in_kind_i,
  input  logic [7:0]                    in_opcode_i,
  input  logic [7:0]                    in_operand_a_i,
  input  logic [7:0]                    in_operand_b_i,
  input  logic [7:0]                    in_operand_c_i,
  input  logic                          full_i,
  output logic                          push_o,
  output brm_pkg::instr_t               item_o
);
  import brm_pkg::*;

  logic [REG_AW-1:0] ra;
  logic [REG_AW-1:0] rb;
  logic [REG_AW-1:0] rc;

  assign ra = in_operand_a_i[REG_AW-1:0];
  assign rb = in_operand_b_i[REG_AW-1:0];
  assign rc = in_operand_c_i[REG_AW-1:0];

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o        = '0;
    item_o.op     = OP_NOP;
    item_o.wa     = ra;
    item_o.addr   = in_operand_a_i[MEM_AW-1:0];
    item_o.imm    = in_operand_b_i;
    item_o.target = in_operand_c_i;
    unique case (in_kind_i)
      KIND_EXEC: begin
        unique case (in_opcode_i)
          OPC_AND:   begin item_o.op = OP_AND;   item_o.p0 = rb; item_o.p1 = rc; end
          OPC_OR:    begin item_o.op = OP_OR;    item_o.p0 = rb; item_o.p1 = rc; end
          OPC_ADD:   begin item_o.op = OP_ADD;   item_o.p0 = rb; item_o.p1 = rc; end
          OPC_MUL:   begin item_o.op = OP_MUL;   item_o.p0 = rb; item_o.p1 = rc; end
          OPC_XOR:   begin item_o.op = OP_XOR;   item_o.p0 = rb; item_o.p1 = rc; end
          OPC_PRINT: begin item_o.op = OP_PRINT; item_o.p0 = ra; end
          OPC_SLEEP: begin item_o.op = OP_SLEEP; item_o.p0 = ra; end
          OPC_LOAD:  begin item_o.op = OP_LOAD;  item_o.p0 = rb; end
          OPC_STORE: begin item_o.op = OP_STORE; item_o.p0 = rb; item_o.p1 = ra; end
          OPC_BNE:   begin item_o.op = OP_BNE;   item_o.p0 = ra; item_o.p1 = rb; end
          OPC_LDI:   begin item_o.op = OP_LDI; end
          OPC_STI:   begin item_o.op = OP_STI;   item_o.p0 = ra; end
          default:   item_o.op = OP_NOP;
        endcase
      end
      KIND_WREG: item_o.op = OP_WREG;
      KIND_WMEM: item_o.op = OP_WMEM;
      KIND_RREG: begin item_o.op = OP_RREG; item_o.p0 = ra; end
      KIND_RMEM: item_o.op = OP_RMEM;
      default:   item_o.op = OP_NOP;
    endcase
  end

endmodule

[hdl/brm_queue.sv]
// Short decoupling queue between the front and back parts.
module brm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  brm_pkg::instr_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output brm_pkg::instr_t head_o
);
  import brm_pkg::*;

  instr_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0]   count_q, count_d;

  assign full_o       = (count_q == QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("queue pop while empty");

endmodule

[hdl/brm_back.sv]
// Execution pipeline: register read, execute and memory access, result stage.
module brm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  brm_pkg::instr_t               head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_print_valid_o,
  output logic [brm_pkg::DATA_W-1:0]    out_print_value_o,
  output logic                          out_sleep_valid_o,
  output logic [brm_pkg::DATA_W-1:0]    out_sleep_seconds_o,
  output logic                          out_jump_taken_o,
  output logic [brm_pkg::DATA_W-1:0]    out_jump_target_o,
  output logic [brm_pkg::DATA_W-1:0]    out_read_data_o
);
  import brm_pkg::*;

  logic [DATA_W-1:0]   rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_q;
  logic [DATA_W-1:0]   dm_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] dm_vld_q;

  logic                advance;
  logic                rf_we;
  logic [DATA_W-1:0]   rf_wd;
  logic [DATA_W-1:0]   rd0_q, rd1_q;

  logic                x_valid_q;
  instr_t              x_instr_q;
  logic [DATA_W-1:0]   op0, op1;
  logic [2*DATA_W-1:0] prod;
  logic                x_we, x_load, x_rmem;
  logic [DATA_W-1:0]   x_wd;
  logic                x_mem_we;
  logic [MEM_AW-1:0]   x_mem_addr;
  logic [DATA_W-1:0]   x_mem_wd;
  logic                x_print, x_sleep, x_jump;
  logic [DATA_W-1:0]   x_print_val, x_sleep_val, x_target, x_rdata;

  logic                m_valid_q;
  logic                m_we_q, m_load_q, m_rmem_q;
  logic [REG_AW-1:0]   m_wa_q;
  logic [DATA_W-1:0]   m_wd_q;
  logic [DATA_W-1:0]   mem_rd_q;
  logic                m_print_q, m_sleep_q, m_jump_q;
  logic [DATA_W-1:0]   m_print_val_q, m_sleep_val_q, m_target_q, m_rdata_q;

  assign advance = !m_valid_q || !out_stall_i;
  assign pop_o   = advance && head_valid_i;

  assign rf_we = m_valid_q && !out_stall_i && m_we_q;
  assign rf_wd = m_load_q ? mem_rd_q : m_wd_q;

  // register file: write from the result stage, read for the queue head
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[m_wa_q] <= rf_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[m_wa_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (rf_we && m_wa_q == head_i.p0) begin
        rd0_q <= rf_wd;
      end else if (rf_vld_q[head_i.p0]) begin
        rd0_q <= rf_mem[head_i.p0];
      end else begin
        rd0_q <= '0;
      end
      if (rf_we && m_wa_q == head_i.p1) begin
        rd1_q <= rf_wd;
      end else if (rf_vld_q[head_i.p1]) begin
        rd1_q <= rf_mem[head_i.p1];
      end else begin
        rd1_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
    end else if (advance) begin
      x_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x_instr_q <= head_i;
    end
  end

  // forward the pending result-stage write
  assign op0  = (m_valid_q && m_we_q && m_wa_q == x_instr_q.p0) ? rf_wd : rd0_q;
  assign op1  = (m_valid_q && m_we_q && m_wa_q == x_instr_q.p1) ? rf_wd : rd1_q;
  assign prod = {{DATA_W{1'b0}}, op0} * {{DATA_W{1'b0}}, op1};

  always_comb begin
    x_we        = 1'b0;
    x_load      = 1'b0;
    x_rmem      = 1'b0;
    x_wd        = '0;
    x_mem_we    = 1'b0;
    x_mem_addr  = op0[MEM_AW-1:0];
    x_mem_wd    = x_instr_q.imm;
    x_print     = 1'b0;
    x_sleep     = 1'b0;
    x_jump      = 1'b0;
    x_print_val = '0;
    x_sleep_val = '0;
    x_target    = '0;
    x_rdata     = '0;
    unique case (x_instr_q.op)
      OP_AND:   begin x_we = 1'b1; x_wd = op0 & op1; end
      OP_OR:    begin x_we = 1'b1; x_wd = op0 | op1; end
      OP_ADD:   begin x_we = 1'b1; x_wd = op0 + op1; end
      OP_MUL:   begin x_we = 1'b1; x_wd = prod[DATA_W-1:0]; end
      OP_XOR:   begin x_we = 1'b1; x_wd = op0 ^ op1; end
      OP_PRINT: begin x_print = 1'b1; x_print_val = op0; end
      OP_SLEEP: begin x_sleep = 1'b1; x_sleep_val = op0; end
      OP_LOAD:  begin x_we = 1'b1; x_load = 1'b1; end
      OP_STORE: begin x_mem_we = 1'b1; x_mem_wd = op1; end
      OP_BNE: begin
        if (op0 != op1) begin
          x_jump   = 1'b1;
          x_target = x_instr_q.target;
        end
      end
      OP_LDI, OP_WREG: begin x_we = 1'b1; x_wd = x_instr_q.imm; end
      OP_STI:   x_mem_we = 1'b1;
      OP_WMEM:  begin x_mem_we = 1'b1; x_mem_addr = x_instr_q.addr; end
      OP_RREG:  x_rdata = op0;
      OP_RMEM:  begin x_rmem = 1'b1; x_mem_addr = x_instr_q.addr; end
      default:  x_we = 1'b0;
    endcase
  end

  // data memory: one access per instruction in the execute stage
  always_ff @(posedge clk_i) begin
    if (advance && x_valid_q) begin
      if (x_mem_we) begin
        dm_mem[x_mem_addr] <= x_mem_wd;
      end
      mem_rd_q <= dm_vld_q[x_mem_addr] ? dm_mem[x_mem_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dm_vld_q <= '0;
    end else if (advance && x_valid_q && x_mem_we) begin
      dm_vld_q[x_mem_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= x_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_we_q        <= x_we;
      m_load_q      <= x_load;
      m_rmem_q      <= x_rmem;
      m_wa_q        <= x_instr_q.wa;
      m_wd_q        <= x_wd;
      m_print_q     <= x_print;
      m_sleep_q     <= x_sleep;
      m_jump_q      <= x_jump;
      m_print_val_q <= x_print_val;
      m_sleep_val_q <= x_sleep_val;
      m_target_q    <= x_target;
      m_rdata_q     <= x_rdata;
    end
  end

  assign out_valid_o         = m_valid_q;
  assign out_print_valid_o   = m_print_q;
  assign out_print_value_o   = m_print_val_q;
  assign out_sleep_valid_o   = m_sleep_q;
  assign out_sleep_seconds_o = m_sleep_val_q;
  assign out_jump_taken_o    = m_jump_q;
  assign out_jump_target_o   = m_target_q;
  assign out_read_data_o     = m_rmem_q ? mem_rd_q : m_rdata_q;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && out_stall_i |=> m_valid_q && $stable(x_valid_q))
    else $error("pipeline moved while result stalled");

  a_one_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_print_valid_o, out_sleep_valid_o, out_jump_taken_o}))
    else $error("more than one report in a result");

  a_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_jump_taken_o |-> out_jump_target_o == '0)
    else $error("jump target without taken branch");

  a_write_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> out_valid_o && !out_stall_i)
    else $error("register write without result beat");

endmodule
